FILE: hdl/esl_pkg.sv
`timescale 1ns / 1ps
package esl_pkg;

  localparam int CFG_W            = 13;
  localparam int DATA_DEPTH_DEF   = 4096;
  localparam int NAME_CAP_DEF     = 64;
  localparam int ID_CAP_DEF       = 512;
  localparam int LINE_HEADROOM_DEF = 128;
  localparam logic [CFG_W-1:0] MAX_EVENT_RESET = 13'd4096;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    REQ_FEED      = 3'd0,
    REQ_FINISH    = 3'd1,
    REQ_READ_DATA = 3'd2,
    REQ_READ_NAME = 3'd3,
    REQ_READ_ID   = 3'd4
  } esl_req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EVENT      = 2'd1,
    ST_ERROR      = 2'd2,
    ST_INCOMPLETE = 2'd3
  } esl_status_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_DATA = 2'd1,
    RD_NAME = 2'd2,
    RD_ID   = 2'd3
  } esl_rdsel_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  byte_in;
    logic [11:0] read_index;
  } esl_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [12:0] data_length;
    logic [5:0]  name_length;
    logic        name_is_default;
    logic        id_valid;
    logic [8:0]  id_length;
  } esl_out_t;

  typedef struct packed {
    logic [1:0]  status;
    esl_rdsel_t  rd_sel;
    logic [12:0] data_length;
    logic [5:0]  name_length;
    logic        name_is_default;
    logic        id_valid;
    logic [8:0]  id_length;
  } esl_res_t;

  typedef struct packed {
    logic [7:0] data_q;
    logic [7:0] name_q;
    logic [7:0] id_q;
  } esl_rd_t;

endpackage

FILE: hdl/esl_ram.sv
`timescale 1ns / 1ps
module esl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/esl_core.sv
`timescale 1ns / 1ps
module esl_core #(
  parameter int DATA_DEPTH    = esl_pkg::DATA_DEPTH_DEF,
  parameter int NAME_CAP      = esl_pkg::NAME_CAP_DEF,
  parameter int ID_CAP        = esl_pkg::ID_CAP_DEF,
  parameter int LINE_HEADROOM = esl_pkg::LINE_HEADROOM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  esl_pkg::esl_in_t           item,
  input  logic [esl_pkg::CFG_W-1:0]  max_cfg,
  output esl_pkg::esl_res_t          res,
  output esl_pkg::esl_rd_t           rd
);
  import esl_pkg::*;

  localparam int DW  = $clog2(DATA_DEPTH);
  localparam int CW  = $clog2(DATA_DEPTH + 1);
  localparam int MW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int LW  = $clog2(DATA_DEPTH + LINE_HEADROOM + 1);
  localparam int PW  = LW + 1;
  localparam int NW  = $clog2(NAME_CAP);
  localparam int NAW = $clog2(2 * NAME_CAP);
  localparam int IW  = $clog2(ID_CAP);
  localparam int IAW = $clog2(3 * ID_CAP);

  typedef enum logic [1:0] {PH_NAME, PH_COMMENT, PH_VALUE} phase_t;
  typedef enum logic [1:0] {K_OTHER, K_DATA, K_EVENT, K_ID} kind_t;

  function automatic logic [7:0] kw_data(input logic [2:0] n);
    case (n)
      3'd0:    kw_data = 8'h64;
      3'd1:    kw_data = 8'h61;
      3'd2:    kw_data = 8'h74;
      3'd3:    kw_data = 8'h61;
      default: kw_data = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_event(input logic [2:0] n);
    case (n)
      3'd0:    kw_event = 8'h65;
      3'd1:    kw_event = 8'h76;
      3'd2:    kw_event = 8'h65;
      3'd3:    kw_event = 8'h6E;
      3'd4:    kw_event = 8'h74;
      default: kw_event = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_id(input logic [2:0] n);
    case (n)
      3'd0:    kw_id = 8'h69;
      3'd1:    kw_id = 8'h64;
      default: kw_id = 8'h00;
    endcase
  endfunction

  function automatic logic [IAW-1:0] id_base(input logic [1:0] bank);
    case (bank)
      2'd1:    id_base = IAW'(ID_CAP);
      2'd2:    id_base = IAW'(2 * ID_CAP);
      default: id_base = '0;
    endcase
  endfunction

  logic [CW-1:0] data_count_r, data_count_nxt;
  logic [NW-1:0] name_len_r, name_len_nxt;
  logic          name_bank_r, name_bank_nxt;
  logic [1:0]    name_zero_r, name_zero_nxt;
  logic [1:0]    id_cur_r, id_cur_nxt, id_last_r, id_last_nxt, id_spare_r, id_spare_nxt;
  logic [IW-1:0] id_cur_len_r, id_cur_len_nxt, id_last_len_r, id_last_len_nxt;
  logic          last_present_r, last_present_nxt;
  logic          pending_r, pending_nxt;
  logic          prev_cr_r, prev_cr_nxt;
  logic [LW-1:0] line_count_r, line_count_nxt;
  logic [LW-1:0] value_count_r, value_count_nxt;
  phase_t        phase_r, phase_nxt;
  kind_t         kind_r, kind_nxt;
  logic [2:0]    nlen_r, nlen_nxt;
  logic          cand_d_r, cand_d_nxt, cand_e_r, cand_e_nxt, cand_i_r, cand_i_nxt;
  logic          at_start_r, at_start_nxt;
  logic          has_nul_r, has_nul_nxt;

  logic           d_we, n_we, i_we;
  logic [DW-1:0]  d_waddr, d_raddr;
  logic [NAW-1:0] n_waddr, n_raddr;
  logic [IAW-1:0] i_waddr, i_raddr;
  logic [7:0]     d_wdata;

  logic [MW-1:0]  cfg_x;
  logic [CW-1:0]  eff;
  logic [LW-1:0]  lim;
  logic [CW-1:0]  dc_e;
  logic [NW-1:0]  nl_e;
  logic [IW-1:0]  cl_e;
  logic           named_e;
  kind_t          f_kind, e_kind;
  logic [LW-1:0]  v_e;
  logic           sep;
  logic [PW-1:0]  dsum, vpos;
  logic [7:0]     b;
  logic [2:0]     req;

  assign b       = item.byte_in;
  assign req     = item.req_type;
  assign cfg_x   = MW'(max_cfg);
  assign eff     = (max_cfg == '0) ? CW'(1) :
                   (cfg_x > MW'(DATA_DEPTH)) ? CW'(DATA_DEPTH) : CW'(cfg_x);
  assign lim     = LW'(eff) + LW'(LINE_HEADROOM);
  assign dc_e    = pending_r ? '0 : data_count_r;
  assign nl_e    = pending_r ? '0 : name_len_r;
  assign cl_e    = pending_r ? '0 : id_cur_len_r;
  assign named_e = (nl_e != '0) && !name_zero_r[name_bank_r];
  assign v_e     = (phase_r == PH_VALUE) ? value_count_r : '0;
  assign sep     = (dc_e != '0);
  assign dsum    = PW'(dc_e) + PW'(sep) + PW'(v_e);
  assign vpos    = PW'(dc_e) + PW'(sep) + PW'(value_count_r);

  always_comb begin
    if (cand_d_r && nlen_r == 3'd4) begin
      f_kind = K_DATA;
    end else if (cand_e_r && nlen_r == 3'd5) begin
      f_kind = K_EVENT;
    end else if (cand_i_r && nlen_r == 3'd2) begin
      f_kind = K_ID;
    end else begin
      f_kind = K_OTHER;
    end
    e_kind = (phase_r == PH_VALUE) ? kind_r : f_kind;
  end

  always_comb begin
    data_count_nxt   = data_count_r;
    name_len_nxt     = name_len_r;
    name_bank_nxt    = name_bank_r;
    name_zero_nxt    = name_zero_r;
    id_cur_nxt       = id_cur_r;
    id_last_nxt      = id_last_r;
    id_spare_nxt     = id_spare_r;
    id_cur_len_nxt   = id_cur_len_r;
    id_last_len_nxt  = id_last_len_r;
    last_present_nxt = last_present_r;
    pending_nxt      = pending_r;
    prev_cr_nxt      = prev_cr_r;
    line_count_nxt   = line_count_r;
    value_count_nxt  = value_count_r;
    phase_nxt        = phase_r;
    kind_nxt         = kind_r;
    nlen_nxt         = nlen_r;
    cand_d_nxt       = cand_d_r;
    cand_e_nxt       = cand_e_r;
    cand_i_nxt       = cand_i_r;
    at_start_nxt     = at_start_r;
    has_nul_nxt      = has_nul_r;
    d_we    = 1'b0;
    d_waddr = DW'(vpos);
    d_wdata = b;
    n_we    = 1'b0;
    n_waddr = (name_bank_r ? '0 : NAW'(NAME_CAP)) + NAW'(value_count_r);
    i_we    = 1'b0;
    i_waddr = id_base(id_spare_r) + IAW'(value_count_r);
    res     = '0;
    res.rd_sel = RD_NONE;

    unique case (req)
      REQ_FEED: begin
        data_count_nxt = dc_e;
        name_len_nxt   = nl_e;
        id_cur_len_nxt = cl_e;
        pending_nxt    = 1'b0;
        if (b == CH_LF && prev_cr_r) begin
          prev_cr_nxt = 1'b0;
        end else if (b == CH_LF || b == CH_CR) begin
          prev_cr_nxt = (b == CH_CR);
          if (line_count_r == '0) begin
            if (dc_e == '0) begin
              name_len_nxt   = '0;
              id_cur_len_nxt = '0;
            end else begin
              if (cl_e != '0) begin
                id_last_nxt      = id_cur_r;
                id_last_len_nxt  = cl_e;
                id_cur_nxt       = id_last_r;
                id_cur_len_nxt   = '0;
                last_present_nxt = 1'b1;
              end
              res.status          = ST_EVENT;
              res.data_length     = 13'(dc_e);
              res.name_length     = 6'(nl_e);
              res.name_is_default = !named_e;
              res.id_valid        = last_present_r || (cl_e != '0);
              res.id_length       = (cl_e != '0) ? 9'(cl_e) :
                                    last_present_r ? 9'(id_last_len_r) : 9'd0;
              pending_nxt         = 1'b1;
            end
          end else if (phase_r != PH_COMMENT) begin
            unique case (e_kind)
              K_DATA: begin
                if (dsum > PW'(eff)) begin
                  res.status = ST_ERROR;
                end else begin
                  d_we           = sep;
                  d_waddr        = DW'(dc_e);
                  d_wdata        = CH_LF;
                  data_count_nxt = CW'(dsum);
                end
              end
              K_EVENT: begin
                if (PW'(v_e) >= PW'(NAME_CAP)) begin
                  res.status = ST_ERROR;
                end else begin
                  name_bank_nxt = !name_bank_r;
                  name_len_nxt  = NW'(v_e);
                end
              end
              K_ID: begin
                if (phase_r == PH_VALUE && has_nul_r) begin
                  res.status = ST_OK;
                end else if (PW'(v_e) >= PW'(ID_CAP)) begin
                  res.status = ST_ERROR;
                end else begin
                  id_cur_nxt     = id_spare_r;
                  id_spare_nxt   = id_cur_r;
                  id_cur_len_nxt = IW'(v_e);
                end
              end
              default: begin
                res.status = ST_OK;
              end
            endcase
          end
          line_count_nxt  = '0;
          value_count_nxt = '0;
          phase_nxt       = PH_NAME;
          kind_nxt        = K_OTHER;
          nlen_nxt        = '0;
          cand_d_nxt      = 1'b1;
          cand_e_nxt      = 1'b1;
          cand_i_nxt      = 1'b1;
          at_start_nxt    = 1'b0;
          has_nul_nxt     = 1'b0;
        end else begin
          prev_cr_nxt = 1'b0;
          if (line_count_r >= lim) begin
            res.status = ST_ERROR;
          end else begin
            line_count_nxt = line_count_r + LW'(1);
            if (line_count_r == '0 && b == CH_COLON) begin
              phase_nxt = PH_COMMENT;
            end else if (phase_r == PH_NAME) begin
              if (b == CH_COLON) begin
                kind_nxt     = f_kind;
                phase_nxt    = PH_VALUE;
                at_start_nxt = 1'b1;
              end else begin
                cand_d_nxt = cand_d_r && nlen_r < 3'd4 && b == kw_data(nlen_r);
                cand_e_nxt = cand_e_r && nlen_r < 3'd5 && b == kw_event(nlen_r);
                cand_i_nxt = cand_i_r && nlen_r < 3'd2 && b == kw_id(nlen_r);
                if (nlen_r < 3'd7) begin
                  nlen_nxt = nlen_r + 3'd1;
                end
              end
            end else if (phase_r == PH_VALUE) begin
              at_start_nxt = 1'b0;
              if (!(at_start_r && b == CH_SPACE)) begin
                value_count_nxt = value_count_r + LW'(1);
                unique case (kind_r)
                  K_DATA: begin
                    d_we = (vpos < PW'(eff));
                  end
                  K_EVENT: begin
                    n_we = (PW'(value_count_r) < PW'(NAME_CAP));
                    if (value_count_r == '0) begin
                      name_zero_nxt[!name_bank_r] = (b == 8'h00);
                    end
                  end
                  K_ID: begin
                    i_we = (PW'(value_count_r) < PW'(ID_CAP));
                    if (b == 8'h00) begin
                      has_nul_nxt = 1'b1;
                    end
                  end
                  default: begin
                    d_we = 1'b0;
                  end
                endcase
              end
            end
          end
        end
      end
      REQ_FINISH: begin
        data_count_nxt = dc_e;
        name_len_nxt   = nl_e;
        id_cur_len_nxt = cl_e;
        pending_nxt    = 1'b0;
        if (line_count_r != '0 || dc_e != '0 || named_e) begin
          res.status = ST_INCOMPLETE;
        end
      end
      REQ_READ_DATA: begin
        if (32'(item.read_index) < 32'(data_count_r) &&
            32'(item.read_index) < 32'(DATA_DEPTH)) begin
          res.rd_sel = RD_DATA;
        end
      end
      REQ_READ_NAME: begin
        if (32'(item.read_index) < 32'(name_len_r)) begin
          res.rd_sel = RD_NAME;
        end
      end
      REQ_READ_ID: begin
        if (last_present_r && 32'(item.read_index) < 32'(id_last_len_r)) begin
          res.rd_sel = RD_ID;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  assign d_raddr = DW'(item.read_index);
  assign n_raddr = (name_bank_r ? NAW'(NAME_CAP) : '0) + NAW'(item.read_index);
  assign i_raddr = id_base(id_last_r) + IAW'(item.read_index);

  esl_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data_ram (
    .clk(clk), .we(acc && d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(acc), .raddr(d_raddr), .rdata(rd.data_q)
  );

  esl_ram #(.WIDTH(8), .DEPTH(2 * NAME_CAP)) u_name_ram (
    .clk(clk), .we(acc && n_we), .waddr(n_waddr), .wdata(b),
    .re(acc), .raddr(n_raddr), .rdata(rd.name_q)
  );

  esl_ram #(.WIDTH(8), .DEPTH(3 * ID_CAP)) u_id_ram (
    .clk(clk), .we(acc && i_we), .waddr(i_waddr), .wdata(b),
    .re(acc), .raddr(i_raddr), .rdata(rd.id_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_count_r   <= '0;
      name_len_r     <= '0;
      name_bank_r    <= 1'b0;
      name_zero_r    <= '0;
      id_cur_r       <= 2'd0;
      id_last_r      <= 2'd1;
      id_spare_r     <= 2'd2;
      id_cur_len_r   <= '0;
      id_last_len_r  <= '0;
      last_present_r <= 1'b0;
      pending_r      <= 1'b0;
      prev_cr_r      <= 1'b0;
      line_count_r   <= '0;
      value_count_r  <= '0;
      phase_r        <= PH_NAME;
      kind_r         <= K_OTHER;
      nlen_r         <= '0;
      cand_d_r       <= 1'b1;
      cand_e_r       <= 1'b1;
      cand_i_r       <= 1'b1;
      at_start_r     <= 1'b0;
      has_nul_r      <= 1'b0;
    end else if (acc) begin
      data_count_r   <= data_count_nxt;
      name_len_r     <= name_len_nxt;
      name_bank_r    <= name_bank_nxt;
      name_zero_r    <= name_zero_nxt;
      id_cur_r       <= id_cur_nxt;
      id_last_r      <= id_last_nxt;
      id_spare_r     <= id_spare_nxt;
      id_cur_len_r   <= id_cur_len_nxt;
      id_last_len_r  <= id_last_len_nxt;
      last_present_r <= last_present_nxt;
      pending_r      <= pending_nxt;
      prev_cr_r      <= prev_cr_nxt;
      line_count_r   <= line_count_nxt;
      value_count_r  <= value_count_nxt;
      phase_r        <= phase_nxt;
      kind_r         <= kind_nxt;
      nlen_r         <= nlen_nxt;
      cand_d_r       <= cand_d_nxt;
      cand_e_r       <= cand_e_nxt;
      cand_i_r       <= cand_i_nxt;
      at_start_r     <= at_start_nxt;
      has_nul_r      <= has_nul_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_id_banks_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    id_cur_r != id_last_r && id_cur_r != id_spare_r && id_last_r != id_spare_r)
    else $error("id bank pointers overlap");

  a_pending_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> data_count_r != '0)
    else $error("dispatched event left no data");
`endif

endmodule

FILE: hdl/event_stream_line_parser.sv
`timescale 1ns / 1ps
// Server-sent-events line parser. Every request (feed byte, finish, or a read
// of the data, event name or last id store) is parsed against the held state
// and the memories as it is accepted, and its result appears from the output
// register on the next cycle, so a new request is taken every cycle while the
// result side keeps up. All stores are registered-read memories written and
// read once per cycle; no clearing pass follows reset.
module event_stream_line_parser #(
  parameter int DATA_DEPTH    = esl_pkg::DATA_DEPTH_DEF,
  parameter int NAME_CAP      = esl_pkg::NAME_CAP_DEF,
  parameter int ID_CAP        = esl_pkg::ID_CAP_DEF,
  parameter int LINE_HEADROOM = esl_pkg::LINE_HEADROOM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  esl_pkg::esl_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output esl_pkg::esl_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [esl_pkg::CFG_W-1:0] cfg_data
);
  import esl_pkg::*;

  logic              acc;
  logic              out_valid_r;
  esl_res_t          res, res_r;
  esl_rd_t           rd;
  logic [CFG_W-1:0]  max_cfg_r;
  logic [7:0]        rbyte;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  esl_core #(
    .DATA_DEPTH(DATA_DEPTH), .NAME_CAP(NAME_CAP),
    .ID_CAP(ID_CAP), .LINE_HEADROOM(LINE_HEADROOM)
  ) u_core (
    .clk(clk), .rst_n(rst_n), .acc(acc), .item(in_data),
    .max_cfg(max_cfg_r), .res(res), .rd(rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      max_cfg_r   <= MAX_EVENT_RESET;
    end else begin
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        max_cfg_r <= cfg_data;
      end
    end
    if (acc) begin
      res_r <= res;
    end
  end

  always_comb begin
    unique case (res_r.rd_sel)
      RD_DATA: rbyte = rd.data_q;
      RD_NAME: rbyte = rd.name_q;
      RD_ID:   rbyte = rd.id_q;
      default: rbyte = 8'h00;
    endcase
  end

  assign out_data.status          = res_r.status;
  assign out_data.read_byte       = rbyte;
  assign out_data.data_length     = res_r.data_length;
  assign out_data.name_length     = res_r.name_length;
  assign out_data.name_is_default = res_r.name_is_default;
  assign out_data.id_valid        = res_r.id_valid;
  assign out_data.id_length       = res_r.id_length;

`ifndef NO_ASSERTIONS
  a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted request produced no result");

  a_lengths_only_on_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_EVENT |->
      out_data.data_length == '0 && out_data.name_length == '0 &&
      out_data.id_length == '0)
    else $error("lengths reported without dispatch");

  a_read_byte_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.read_byte == 8'h00)
    else $error("read byte on non-read request");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import esl_pkg::*;

  typedef enum int {PHASE_KEY, PHASE_COMMENT, PHASE_VALUE} line_phase_e;
  typedef enum int {FIELD_OTHER, FIELD_DATA, FIELD_EVENT, FIELD_ID} field_e;

  localparam int DATA_DEPTH = DATA_DEPTH_DEF;
  localparam int NAME_CAP   = NAME_CAP_DEF;
  localparam int ID_CAP     = ID_CAP_DEF;
  localparam int HEADROOM   = LINE_HEADROOM_DEF;
  localparam int STALL_LIMIT = 2000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  esl_in_t in_data;
  esl_out_t out_data;
  logic [CFG_W-1:0] cfg_data;

  event_stream_line_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // parser mirror
  logic [CFG_W-1:0] event_limit;
  logic [7:0] data_mem [DATA_DEPTH];
  logic [7:0] name_mem [2*NAME_CAP];
  logic [7:0] id_mem [3*ID_CAP];
  int stored_len, name_len, name_bank;
  int id_cur, id_last, id_spare, id_cur_len, id_last_len;
  bit id_known, clear_due, saw_cr;
  int line_bytes, value_bytes, key_len;
  line_phase_e phase;
  field_e field_kind;
  bit may_data, may_event, may_id, value_start, id_has_nul;

  esl_out_t expected_results[$];
  int errors = 0;
  int sent = 0;
  int burst_left = 0;
  bit hold_request = 0;

  function automatic int limit_now();
    int m;
    m = event_limit;
    if (m < 1) m = 1;
    if (m > DATA_DEPTH) m = DATA_DEPTH;
    return m;
  endfunction

  function automatic void restart_line();
    line_bytes = 0;
    value_bytes = 0;
    phase = PHASE_KEY;
    field_kind = FIELD_OTHER;
    key_len = 0;
    may_data = 1;
    may_event = 1;
    may_id = 1;
    value_start = 0;
    id_has_nul = 0;
  endfunction

  function automatic field_e key_field();
    if (may_data && key_len == 4) return FIELD_DATA;
    if (may_event && key_len == 5) return FIELD_EVENT;
    if (may_id && key_len == 2) return FIELD_ID;
    return FIELD_OTHER;
  endfunction

  function automatic bit name_present();
    return name_len > 0 && name_mem[(name_bank & 1) * NAME_CAP] != 0;
  endfunction

  function automatic void apply_clear();
    if (!clear_due) return;
    stored_len = 0;
    name_len = 0;
    id_cur_len = 0;
    clear_due = 0;
  endfunction

  function automatic void key_char(logic [7:0] b);
    string kd, ke, ki;
    kd = "data";
    ke = "event";
    ki = "id";
    may_data = may_data && key_len < 4 && b == kd[key_len < 4 ? key_len : 0];
    may_event = may_event && key_len < 5 && b == ke[key_len < 5 ? key_len : 0];
    may_id = may_id && key_len < 2 && b == ki[key_len < 2 ? key_len : 0];
    if (key_len < 7) key_len++;
  endfunction

  function automatic void value_char(logic [7:0] b);
    int pos;
    if (value_start) begin
      value_start = 0;
      if (b == CH_SPACE) return;
    end
    if (field_kind == FIELD_DATA) begin
      pos = stored_len + (stored_len > 0 ? 1 : 0) + value_bytes;
      if (pos < limit_now()) data_mem[pos] = b;
    end else if (field_kind == FIELD_EVENT) begin
      if (value_bytes < NAME_CAP) name_mem[((name_bank ^ 1) & 1) * NAME_CAP + value_bytes] = b;
    end else if (field_kind == FIELD_ID) begin
      if (b == 0) id_has_nul = 1;
      if (value_bytes < ID_CAP) id_mem[(id_spare % 3) * ID_CAP + value_bytes] = b;
    end
    value_bytes++;
  endfunction

  function automatic void dispatch_event(inout esl_out_t res);
    int t;
    if (stored_len == 0) begin
      name_len = 0;
      id_cur_len = 0;
      return;
    end
    if (id_cur_len > 0) begin
      t = id_last;
      id_last = id_cur;
      id_last_len = id_cur_len;
      id_cur = t;
      id_cur_len = 0;
      id_known = 1;
    end
    res.status = ST_EVENT;
    res.data_length = stored_len[12:0];
    res.name_length = name_len[5:0];
    res.name_is_default = !name_present();
    res.id_valid = id_known;
    res.id_length = id_known ? id_last_len[8:0] : 9'd0;
    clear_due = 1;
  endfunction

  function automatic void close_line(inout esl_out_t res);
    field_e k;
    int v, sep, t;
    if (line_bytes == 0) begin
      dispatch_event(res);
      return;
    end
    if (phase == PHASE_COMMENT) return;
    k = phase == PHASE_VALUE ? field_kind : key_field();
    v = phase == PHASE_VALUE ? value_bytes : 0;
    if (k == FIELD_DATA) begin
      sep = stored_len > 0 ? 1 : 0;
      if (stored_len + sep + v > limit_now()) begin
        res.status = ST_ERROR;
        return;
      end
      if (sep) data_mem[stored_len] = CH_LF;
      stored_len += sep + v;
    end else if (k == FIELD_EVENT) begin
      if (v >= NAME_CAP) begin
        res.status = ST_ERROR;
        return;
      end
      name_bank ^= 1;
      name_len = v;
    end else if (k == FIELD_ID) begin
      if (phase == PHASE_VALUE && id_has_nul) return;
      if (v >= ID_CAP) begin
        res.status = ST_ERROR;
        return;
      end
      t = id_cur;
      id_cur = id_spare;
      id_spare = t;
      id_cur_len = v;
    end
  endfunction

  function automatic void feed_byte(logic [7:0] b, inout esl_out_t res);
    apply_clear();
    if (b == CH_LF && saw_cr) begin
      saw_cr = 0;
      return;
    end
    if (b == CH_LF || b == CH_CR) begin
      close_line(res);
      restart_line();
      saw_cr = (b == CH_CR);
      return;
    end
    saw_cr = 0;
    if (line_bytes >= limit_now() + HEADROOM) begin
      res.status = ST_ERROR;
      return;
    end
    if (line_bytes == 0 && b == CH_COLON) begin
      phase = PHASE_COMMENT;
    end else if (phase == PHASE_KEY) begin
      if (b == CH_COLON) begin
        field_kind = key_field();
        phase = PHASE_VALUE;
        value_start = 1;
      end else begin
        key_char(b);
      end
    end else if (phase == PHASE_VALUE) begin
      value_char(b);
    end
    line_bytes++;
  endfunction

  function automatic esl_out_t parse_request(esl_in_t r);
    esl_out_t res;
    int idx;
    res = '0;
    idx = r.read_index;
    case (r.req_type)
      REQ_FEED: feed_byte(r.byte_in, res);
      REQ_FINISH: begin
        apply_clear();
        res.status = (line_bytes > 0 || stored_len > 0 || name_present()) ? ST_INCOMPLETE : ST_OK;
      end
      REQ_READ_DATA: if (idx < stored_len) res.read_byte = data_mem[idx];
      REQ_READ_NAME: if (idx < name_len && idx < NAME_CAP)
        res.read_byte = name_mem[(name_bank & 1) * NAME_CAP + idx];
      REQ_READ_ID: if (id_known && idx < id_last_len && idx < ID_CAP)
        res.read_byte = id_mem[(id_last % 3) * ID_CAP + idx];
      default: ;
    endcase
    return res;
  endfunction

  function automatic void reset_mirror();
    event_limit = MAX_EVENT_RESET;
    stored_len = 0;
    name_len = 0;
    name_bank = 0;
    id_cur = 0;
    id_last = 1;
    id_spare = 2;
    id_cur_len = 0;
    id_last_len = 0;
    id_known = 0;
    clear_due = 0;
    saw_cr = 0;
    restart_line();
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // result side
  initial begin
    int mode, count;
    out_ready = 0;
    mode = 0;
    count = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_request = 0;
      end else begin
        count++;
        if (count % 64 == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_ready <= 1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (count % 4 == 0);
        endcase
      end
    end
  end

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // acceptance happens at the next rising edge; valid and ready hold until then
  always @(negedge clk) begin
    esl_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report("outstanding requests", 0, 1);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status != want.status) report("status", out_data.status, want.status);
        if (out_data.read_byte != want.read_byte)
          report("read_byte", out_data.read_byte, want.read_byte);
        if (out_data.data_length != want.data_length)
          report("data_length", out_data.data_length, want.data_length);
        if (out_data.name_length != want.name_length)
          report("name_length", out_data.name_length, want.name_length);
        if (out_data.name_is_default != want.name_is_default)
          report("name_is_default", out_data.name_is_default, want.name_is_default);
        if (out_data.id_valid != want.id_valid)
          report("id_valid", out_data.id_valid, want.id_valid);
        if (out_data.id_length != want.id_length)
          report("id_length", out_data.id_length, want.id_length);
      end
    end
  end

  always @(negedge clk) begin
    int idle;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send(logic [2:0] req, logic [7:0] b, logic [11:0] idx);
    esl_in_t r;
    bit rdy;
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    r.req_type = req;
    r.byte_in = b;
    r.read_index = idx;
    in_valid <= 1;
    in_data <= r;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    expected_results.push_back(parse_request(r));
    sent++;
  endtask

  task automatic feed(logic [7:0] b);
    send(REQ_FEED, b, 12'($urandom));
  endtask

  task automatic send_line(string s, int term);
    for (int i = 0; i < s.len(); i++) feed(s[i]);
    if (term == 0) feed(CH_LF);
    else if (term == 1) feed(CH_CR);
    else begin
      feed(CH_CR);
      feed(CH_LF);
    end
  endtask

  task automatic send_repeated(string head, int n, logic [7:0] b);
    for (int i = 0; i < head.len(); i++) feed(head[i]);
    repeat (n) feed(b);
    feed(CH_LF);
  endtask

  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(logic [CFG_W-1:0] v);
    bit rdy;
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 0;
    event_limit = v;
  endtask

  task automatic test_directed();
    send_line("data: hi", 0);
    send_line("event:ping", 2);
    send_line("id: 7", 1);
    send_line("", 0);
    send(REQ_READ_DATA, 0, 0);
    send(REQ_READ_DATA, 0, 1);
    send(REQ_READ_NAME, 0, 3);
    send(REQ_READ_ID, 0, 0);
    send(REQ_READ_DATA, 0, 12'hFFF);
    send(REQ_FINISH, 0, 0);
    send_line(":comment", 0);
    send_line("data:a", 1);
    feed(CH_LF);
    send_line("data", 0);
    send_line("", 2);
    send(3'd5, 8'hFF, 12'hFFF);
    send(3'd7, 8'h00, 12'h000);
    feed("i");
    feed("d");
    feed(CH_COLON);
    feed(8'h00);
    feed(CH_LF);
    send_line("event:x", 0);
    send_line("", 0);
    send_line("data:\xff", 0);
    send(REQ_FINISH, 0, 0);
    send(REQ_READ_ID, 0, 0);
  endtask

  task automatic test_limits();
    set_limit(1);
    send_line("data:ab", 0);
    send_repeated("data:", 140, "q");
    send(REQ_FINISH, 0, 0);
    set_limit(0);
    send_line("data:c", 0);
    send_line("", 0);
    set_limit(5);
    send_line("data:abcde", 0);
    send_line("", 0);
    set_limit(8191);
    send_repeated("event:", 64, "n");
    send_repeated("event:", 63, "n");
    send_repeated("id:", 512, "7");
    send_line("id: 8", 0);
    set_limit(40);
    send_repeated("data:", 40, "x");
    send_line("data:y", 0);
    send_line("", 0);
    send(REQ_READ_DATA, 0, 39);
    send(REQ_READ_DATA, 0, 40);
    send(REQ_READ_NAME, 0, 62);
    send(REQ_READ_ID, 0, 0);
    set_limit(4096);
  endtask

  task automatic test_backpressure();
    drain();
    hold_request = 1;
    repeat (20) send_line("data:z", 0);
    send_line("", 0);
  endtask

  function automatic logic [7:0] value_byte_pick();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic random_line();
    string keys[7] = '{"data", "event", "id", "dat", "ids", "", "retry"};
    string k;
    int n;
    logic [7:0] b;
    k = keys[$urandom_range(0, 6)];
    for (int i = 0; i < k.len(); i++) feed(k[i]);
    if ($urandom_range(0, 7) != 0) feed(CH_COLON);
    if ($urandom_range(0, 1)) feed(CH_SPACE);
    n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 70) : $urandom_range(0, 10);
    repeat (n) begin
      b = value_byte_pick();
      if (b == CH_LF || b == CH_CR) b = "w";
      if (k == "id" && $urandom_range(0, 30) == 0) b = 8'h00;
      feed(b);
    end
    case ($urandom_range(0, 2))
      0: feed(CH_LF);
      1: feed(CH_CR);
      default: begin
        feed(CH_CR);
        feed(CH_LF);
      end
    endcase
  endtask

  task automatic test_random();
    int target;
    logic [CFG_W-1:0] limits[6] = '{13'd0, 13'd3, 13'd40, 13'd4096, 13'd8191, 13'd200};
    foreach (limits[p]) begin
      set_limit(limits[p]);
      target = sent + 50;
      while (sent < target) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: random_line();
          9, 10, 11: feed(CH_LF);
          12, 13: send(REQ_READ_DATA, 0,
                       $urandom_range(0, 1) ? 12'($urandom_range(0, 20)) : 12'($urandom));
          14: send(REQ_READ_NAME, 8'($urandom),
                   $urandom_range(0, 1) ? 12'($urandom_range(0, 8)) : 12'($urandom));
          15: send(REQ_READ_ID, 8'($urandom),
                   $urandom_range(0, 1) ? 12'($urandom_range(0, 8)) : 12'($urandom));
          16: send(REQ_FINISH, 8'($urandom), 12'($urandom));
          17: send(3'($urandom_range(5, 7)), 8'($urandom), 12'($urandom));
          default: feed(8'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    reset_mirror();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_limits();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule

FILE: event_stream_line_parser.f
hdl/esl_pkg.sv
hdl/esl_ram.sv
hdl/esl_core.sv
hdl/event_stream_line_parser.sv
dv/testbench.sv
